// ===== hw/rtl/cti_pkg.sv =====
`default_nettype none

package cti_pkg;

    // Build-time defaults for the top level
    localparam int MAX_CHANNELS_DEF = 16;
    localparam int MAX_ORDER_DEF    = 4;

    // Field widths
    localparam int SAMPLE_W   = 32;
    localparam int CHAN_W     = 4;
    localparam int VAL_W      = 48;
    localparam int ORDER_W    = 3;
    localparam int MASK_W     = 5;
    localparam int STEP_W     = 32;
    localparam int CCNT_W     = 5;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    // One mask bit per codable order
    localparam int ORD_CNT = 1 << ORDER_W;

    // Sum of two values before scaling
    localparam int SUM_W = VAL_W + 1;

    typedef logic signed [VAL_W-1:0] t_val;

    localparam t_val VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam t_val VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORDER_MASK    = 2'd0,
        REG_HALF_STEP     = 2'd1,
        REG_ALWAYS_RESET  = 2'd2,
        REG_CHANNEL_COUNT = 2'd3
    } t_cfg_reg;

    localparam logic [MASK_W-1:0] ORDER_MASK_RST    = 5'd31;
    localparam logic [STEP_W-1:0] HALF_STEP_RST     = 32'h8000_0000;
    localparam logic              ALWAYS_RESET_RST  = 1'b0;
    localparam logic [CCNT_W-1:0] CHANNEL_COUNT_RST = 5'd1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ORD0,
        ST_SUM,
        ST_MLO,
        ST_MHI,
        ST_ACC,
        ST_SAT,
        ST_UPD
    } t_state;

    // Steps of the scaling unit
    typedef enum logic [2:0] {
        SC_HOLD,
        SC_LOAD,
        SC_MLO,
        SC_MHI,
        SC_ACC,
        SC_SAT
    } t_scale_op;

endpackage

`default_nettype wire

// ===== hw/rtl/cti_in_if.sv =====
`default_nettype none

interface cti_in_if;
    import cti_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic [CHAN_W-1:0]          channel;
    logic                       chunk_start;

    modport source (output valid, output sample, output channel, output chunk_start,
                    input ready);
    modport sink   (input valid, input sample, input channel, input chunk_start,
                    output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cti_out_if.sv =====
`default_nettype none

interface cti_out_if;
    import cti_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [VAL_W-1:0]  value;
    logic [ORDER_W-1:0]       order;
    logic                     last;

    modport source (output valid, output value, output order, output last, input ready);
    modport sink   (input valid, input value, input order, input last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cascaded_trapezoid_integrator.sv =====
`default_nettype none

// Cascaded trapezoidal integrator for an interleaved multichannel stream. Each
// input word is one Q16.16 sample of one channel; the block emits, for every
// order set in order_mask from 0 upward, the input (order 0) or its k-th
// trapezoidal integral as a saturated Q32.16 word, the last one flagged. The
// per-channel history sits in one RAM of MAX_CHANNELS*(MAX_ORDER+1) words and
// is read, updated and written back one order at a time, up to the highest
// order set in the mask. Each integral order steps through sum, low and high
// multiply on the single 25x32 multiplier, rounding, saturation and update.
// A sample that reinitializes its channel (first frame, or chunk start with
// always_reset) runs up to MAX_ORDER and skips the multiplier steps, and a
// word with an empty mask is taken without a pass. Stalls on the output hold
// the sequencer. The RAM needs no clearing pass after reset.
module cascaded_trapezoid_integrator #(
    parameter int MAX_CHANNELS = cti_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_ORDER    = cti_pkg::MAX_ORDER_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    cti_in_if.sink                            i_in,
    cti_out_if.source                         o_out,
    input  logic                              i_cfg_we,
    input  logic [cti_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [cti_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import cti_pkg::*;

    localparam int SLOTS      = MAX_ORDER + 1;
    localparam int HIST_DEPTH = MAX_CHANNELS * SLOTS;
    localparam int ADDR_W     = $clog2(HIST_DEPTH);
    localparam int CH_CMP_W   = 9;
    localparam logic [MASK_W-1:0]   MASK_KEEP = MASK_W'((1 << SLOTS) - 1);
    localparam logic [CH_CMP_W-1:0] CH_LAST   = CH_CMP_W'(MAX_CHANNELS - 1);
    localparam logic [ORDER_W-1:0]  TOP_ORDER = ORDER_W'(MAX_ORDER);

    // configuration registers
    logic [MASK_W-1:0] r_order_mask;
    logic [STEP_W-1:0] r_half_step;
    logic              r_always_reset;
    logic [CCNT_W-1:0] r_channel_count;

    // sequencer and datapath
    t_state               r_state, n_state;
    logic                 r_initialized;
    logic                 r_init;
    logic [ORD_CNT-1:0]   r_mask;
    logic [ORDER_W-1:0]   r_hi;
    logic [ORDER_W-1:0]   r_top;
    logic [ORDER_W-1:0]   r_ord;
    logic [ADDR_W-1:0]    r_base;
    t_val                 r_xn;
    t_val                 r_xo;

    // output register
    logic                 r_out_valid;
    t_val                 r_out_value;
    logic [ORDER_W-1:0]   r_out_order;
    logic                 r_out_last;

    logic [CHAN_W-1:0]    ch_tab [1 << CHAN_W];
    logic [CHAN_W-1:0]    in_ch;
    logic [ADDR_W-1:0]    in_base;
    logic [MASK_W-1:0]    mask_in;
    logic [ORDER_W-1:0]   hi_in;
    logic                 need_init;
    logic                 last_ch;
    logic                 in_take;
    t_val                 x_in;

    logic                 mem_we, mem_re;
    logic [ADDR_W-1:0]    mem_waddr, mem_raddr;
    t_val                 mem_wdata, mem_rdata;

    t_scale_op            scale_op;
    t_val                 scale_t;
    t_val                 yo, yn, yn_calc;
    logic signed [VAL_W:0] upd_sum;

    logic                 in_ready;
    logic                 emit, emit_last, step_done;
    t_val                 emit_value;
    logic                 out_free, out_load;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order_mask    <= ORDER_MASK_RST;
            r_half_step     <= HALF_STEP_RST;
            r_always_reset  <= ALWAYS_RESET_RST;
            r_channel_count <= CHANNEL_COUNT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_ORDER_MASK:    r_order_mask    <= i_cfg_data[MASK_W-1:0];
                REG_HALF_STEP:     r_half_step     <= i_cfg_data[STEP_W-1:0];
                REG_ALWAYS_RESET:  r_always_reset  <= i_cfg_data[0];
                REG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[CCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // channel index folded onto the storage
    for (genvar gi = 0; gi < (1 << CHAN_W); gi++) begin : g_ch
        assign ch_tab[gi] = CHAN_W'(gi % MAX_CHANNELS);
    end

    assign in_ch     = ch_tab[i_in.channel];
    assign in_base   = ADDR_W'(in_ch) * ADDR_W'(SLOTS);
    assign mask_in   = r_order_mask & MASK_KEEP;
    assign x_in      = {{(VAL_W-SAMPLE_W){i_in.sample[SAMPLE_W-1]}}, i_in.sample};
    assign need_init = !r_initialized || (r_always_reset && i_in.chunk_start);
    assign last_ch   = (r_channel_count == '0)
                    || ((CCNT_W'(in_ch) + CCNT_W'(1)) >= r_channel_count)
                    || (CH_CMP_W'(in_ch) == CH_LAST);
    assign in_take   = (r_state == ST_IDLE) && i_in.valid;

    // highest order in the mask
    always_comb begin
        hi_in = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (mask_in[i]) hi_in = ORDER_W'(i);
        end
    end

    cti_hist_mem #(
        .DEPTH  (HIST_DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (VAL_W)
    ) u_hist (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_wr_addr (mem_waddr),
        .i_wr_data (mem_wdata),
        .i_re      (mem_re),
        .i_rd_addr (mem_raddr),
        .o_rd_data (mem_rdata)
    );

    cti_scale u_scale (
        .i_clk    (i_clk),
        .i_op     (scale_op),
        .i_xn     (r_xn),
        .i_xo     (r_xo),
        .i_factor (r_half_step),
        .o_t      (scale_t)
    );

    // integral update: old value plus scaled trapezoid, saturated
    assign yo      = r_init ? t_val'(0) : mem_rdata;
    assign upd_sum = {yo[VAL_W-1], yo} + {scale_t[VAL_W-1], scale_t};
    always_comb begin
        if (upd_sum[VAL_W] != upd_sum[VAL_W-1]) begin
            yn_calc = upd_sum[VAL_W] ? VAL_MIN : VAL_MAX;
        end else begin
            yn_calc = upd_sum[VAL_W-1:0];
        end
    end
    assign yn = r_init ? t_val'(0) : yn_calc;

    assign out_free = !r_out_valid || o_out.ready;
    assign out_load = emit && out_free;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and sequencer outputs
    always_comb begin
        n_state    = r_state;
        in_ready   = 1'b0;
        mem_re     = 1'b0;
        mem_raddr  = r_base + ADDR_W'(r_ord);
        mem_we     = 1'b0;
        mem_waddr  = r_base + ADDR_W'(r_ord);
        mem_wdata  = yn;
        emit       = 1'b0;
        emit_value = yn;
        emit_last  = (r_ord == r_hi);
        step_done  = 1'b0;
        scale_op   = SC_HOLD;
        case (r_state)
            ST_IDLE: begin
                in_ready  = 1'b1;
                mem_re    = i_in.valid;
                mem_raddr = in_base;
                if (i_in.valid && (mask_in != '0)) n_state = ST_ORD0;
            end
            ST_ORD0: begin
                emit       = r_mask[r_ord];
                emit_value = r_xn;
                step_done  = !emit || out_free;
                if (step_done) begin
                    mem_we    = 1'b1;
                    mem_wdata = r_xn;
                    n_state   = (r_ord == r_top) ? ST_IDLE : ST_SUM;
                end
            end
            ST_SUM: begin
                scale_op = SC_LOAD;
                mem_re   = 1'b1;
                n_state  = r_init ? ST_UPD : ST_MLO;
            end
            ST_MLO: begin
                scale_op = SC_MLO;
                n_state  = ST_MHI;
            end
            ST_MHI: begin
                scale_op = SC_MHI;
                n_state  = ST_ACC;
            end
            ST_ACC: begin
                scale_op = SC_ACC;
                n_state  = ST_SAT;
            end
            ST_SAT: begin
                scale_op = SC_SAT;
                n_state  = ST_UPD;
            end
            ST_UPD: begin
                emit      = r_mask[r_ord];
                step_done = !emit || out_free;
                if (step_done) begin
                    mem_we  = 1'b1;
                    n_state = (r_ord == r_top) ? ST_IDLE : ST_SUM;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // first-frame tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_initialized <= 1'b0;
            r_init        <= 1'b0;
        end else if (in_take && (mask_in != '0)) begin
            r_init <= need_init;
            if (last_ch) r_initialized <= 1'b1;
        end
    end

    // per-sample working registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_xn   <= x_in;
            r_mask <= ORD_CNT'(mask_in);
            r_hi   <= hi_in;
            r_top  <= need_init ? TOP_ORDER : hi_in;
            r_ord  <= '0;
            r_base <= in_base;
        end else if (step_done) begin
            r_ord <= r_ord + ORDER_W'(1);
            if (r_state == ST_ORD0) begin
                r_xo <= r_init ? -r_xn : mem_rdata;
            end else begin
                r_xo <= yo;
                r_xn <= yn;
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_value <= emit_value;
            r_out_order <= r_ord;
            r_out_last  <= emit_last;
        end
    end

    assign i_in.ready  = in_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.value = r_out_value;
    assign o_out.order = r_out_order;
    assign o_out.last  = r_out_last;

    // history writes stay inside the RAM
    a_wr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> ({1'b0, mem_waddr} < (ADDR_W+1)'(HIST_DEPTH)))
        else $error("history write beyond RAM depth");

    // integral orders run from 1 to the item's top order
    a_ord_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SUM || r_state == ST_MLO || r_state == ST_MHI ||
         r_state == ST_ACC || r_state == ST_SAT || r_state == ST_UPD)
        |-> (r_ord != '0 && r_ord <= r_top))
        else $error("order counter out of range");

    // reinitializing samples bypass the multiplier
    a_init_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |-> !(r_state == ST_MLO || r_state == ST_MHI ||
                     r_state == ST_ACC || r_state == ST_SAT))
        else $error("multiplier used on a reinitializing sample");

    // the flagged word closes an ordinary sample
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && emit_last && !r_init) |=> (r_state == ST_IDLE))
        else $error("sequencer busy after last word");

endmodule

`default_nettype wire

// ===== hw/rtl/cti_hist_mem.sv =====
`default_nettype none

// History store: one write port, one registered read port
module cti_hist_mem #(
    parameter int DEPTH  = cti_pkg::MAX_CHANNELS_DEF * (cti_pkg::MAX_ORDER_DEF + 1),
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int DATA_W = cti_pkg::VAL_W
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // read data holds until the next read
        if (i_re) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== hw/rtl/cti_scale.sv =====
`default_nettype none

// Trapezoid product: round(|xn + xo| * factor / 2^32) with sign, saturated.
// One 25x32 multiplier, used for the low and then the high half of the sum.
module cti_scale (
    input  logic                          i_clk,
    input  cti_pkg::t_scale_op            i_op,
    input  cti_pkg::t_val                 i_xn,
    input  cti_pkg::t_val                 i_xo,
    input  logic [cti_pkg::STEP_W-1:0]    i_factor,
    output cti_pkg::t_val                 o_t
);
    import cti_pkg::*;

    localparam int LO_W    = 24;
    localparam int HI_W    = SUM_W - LO_W;
    localparam int PLO_W   = LO_W + STEP_W;
    localparam int PROD_W  = HI_W + STEP_W;
    localparam int ACC_W   = PROD_W + LO_W;
    localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (STEP_W - 1);

    logic [SUM_W-1:0]  sum_w;
    logic [HI_W-1:0]   mul_a;
    logic [PROD_W-1:0] mul_p;
    logic [ACC_W-1:0]  acc;
    t_val              sat_t;

    logic              r_neg;
    logic [SUM_W-1:0]  r_mag;
    logic [PLO_W-1:0]  r_plo;
    logic [PROD_W-1:0] r_phi;
    logic [VAL_W-1:0]  r_q;
    t_val              r_t;

    assign sum_w = {i_xn[VAL_W-1], i_xn} + {i_xo[VAL_W-1], i_xo};

    // shared multiplier
    assign mul_a = (i_op == SC_MLO) ? HI_W'(r_mag[LO_W-1:0]) : r_mag[SUM_W-1:LO_W];
    assign mul_p = PROD_W'(mul_a) * PROD_W'(i_factor);

    // recombine halves and round half up on the magnitude
    assign acc = {r_phi, {LO_W{1'b0}}} + ACC_W'(r_plo) + ROUND_HALF;

    // apply sign and clamp to 48 bits
    always_comb begin
        if (!r_neg) begin
            sat_t = r_q[VAL_W-1] ? VAL_MAX : t_val'(r_q);
        end else if (r_q[VAL_W-1] && (|r_q[VAL_W-2:0])) begin
            sat_t = VAL_MIN;
        end else begin
            sat_t = t_val'(-r_q);
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            SC_LOAD: begin
                r_neg <= sum_w[SUM_W-1];
                r_mag <= sum_w[SUM_W-1] ? (~sum_w + SUM_W'(1)) : sum_w;
            end
            SC_MLO: r_plo <= mul_p[PLO_W-1:0];
            SC_MHI: r_phi <= mul_p;
            SC_ACC: r_q   <= acc[STEP_W +: VAL_W];
            SC_SAT: r_t   <= sat_t;
            default: ;
        endcase
    end

    assign o_t = r_t;

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cti_pkg::*;

    localparam int SETTLE      = 40;    // cycles after the last word before the block is idle
    localparam int QUIET_LIMIT = 4000;  // cycles without any handshake before giving up
    localparam int SLOT_CNT    = MAX_ORDER_DEF + 1;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic [CHAN_W-1:0]          channel;
        logic                       start;
        bit                         drain_first;
    } t_sample_word;

    typedef struct {
        t_val               value;
        logic [ORDER_W-1:0] order;
        logic               last;
    } t_integral_word;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    cti_in_if  in_if ();
    cti_out_if out_if ();

    cascaded_trapezoid_integrator u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // register shadow, as last written
    logic [MASK_W-1:0] cfg_mask         = ORDER_MASK_RST;
    logic [STEP_W-1:0] cfg_step         = HALF_STEP_RST;
    logic              cfg_always_reset = ALWAYS_RESET_RST;
    logic [CCNT_W-1:0] cfg_chans        = CHANNEL_COUNT_RST;

    // per-channel history: slot 0 previous input, slot k integral of order k
    longint hist [MAX_CHANNELS_DEF][SLOT_CNT];
    bit     hist_ready;

    // stimulus-side view of which channels hold written history
    bit ch_ready [MAX_CHANNELS_DEF];
    bit gen_ready;

    t_sample_word   samples_todo [$];
    t_integral_word integrals_due [$];
    t_sample_word   nxt;
    t_integral_word due;

    int in_gap;
    int out_hold;
    int quiet_cycles;
    int mismatches;
    bit no_gaps_in;
    bit no_stall_out;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int chan_limit();
        int n;
        n = cfg_chans;
        if (n < 1) n = 1;
        if (n > MAX_CHANNELS_DEF) n = MAX_CHANNELS_DEF;
        return n;
    endfunction

    function automatic longint clamp_val(longint v);
        if (v > longint'(VAL_MAX)) return longint'(VAL_MAX);
        if (v < longint'(VAL_MIN)) return longint'(VAL_MIN);
        return v;
    endfunction

    // sum * half_step / 2^32, rounded half away from zero, saturated
    function automatic longint trapezoid_area(longint sum, logic [STEP_W-1:0] step);
        longint unsigned mag;
        logic [95:0]     prod;
        longint          q;
        mag  = (sum < 0) ? -sum : sum;
        prod = mag * step + 32'h8000_0000;
        q    = longint'(prod[95:32]);
        return clamp_val((sum < 0) ? -q : q);
    endfunction

    // one accepted sample: update history, queue the words it should produce
    function automatic void trapezoid_step(logic signed [SAMPLE_W-1:0] smp,
                                           logic [CHAN_W-1:0] ch, logic start);
        int             depth;
        int             k;
        longint         x_new;
        longint         x_old;
        longint         y_old;
        longint         y_new;
        t_integral_word words [$];
        t_integral_word w;
        if (cfg_mask == 0) return;
        depth = 0;
        while ((cfg_mask >> depth) != 0) depth++;
        if (!hist_ready || (cfg_always_reset && start)) begin
            hist[ch][0] = -longint'(smp);
            for (k = 1; k < SLOT_CNT; k++) hist[ch][k] = 0;
        end
        if (int'(ch) + 1 >= chan_limit()) hist_ready = 1'b1;
        x_new = smp;
        x_old = hist[ch][0];
        hist[ch][0] = x_new;
        for (k = 0; k < depth; k++) begin
            if (k > 0) begin
                y_old = hist[ch][k];
                y_new = clamp_val(y_old + trapezoid_area(x_new + x_old, cfg_step));
                x_old = y_old;
                x_new = y_new;
                hist[ch][k] = y_new;
            end
            if (cfg_mask[k]) begin
                w.value = t_val'(x_new);
                w.order = k[ORDER_W-1:0];
                w.last  = 1'b0;
                words.push_back(w);
            end
        end
        words[$].last = 1'b1;
        foreach (words[i]) integrals_due.push_back(words[i]);
    endfunction

    // queue a sample unless it would read history never written; 1 if queued
    function automatic bit add_sample(logic signed [SAMPLE_W-1:0] smp, logic [CHAN_W-1:0] ch,
                                      logic start, bit drain);
        t_sample_word s;
        if (cfg_mask != 0 && gen_ready && !ch_ready[ch] && !(cfg_always_reset && start))
            return 1'b0;
        s.sample      = smp;
        s.channel     = ch;
        s.start       = start;
        s.drain_first = drain;
        samples_todo.push_back(s);
        if (cfg_mask != 0) begin
            if (!gen_ready || (cfg_always_reset && start)) ch_ready[ch] = 1'b1;
            if (int'(ch) + 1 >= chan_limit()) gen_ready = 1'b1;
        end
        return 1'b1;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return $urandom_range(0, 511) - 256;
            3:       return '0;
            default: return $urandom;
        endcase
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // interleaved frames with random content, a few dropped or stray words
    function automatic int queue_frames(int frames, int chunk_len, int drain_at);
        int   n;
        int   f;
        int   c;
        int   made;
        logic start;
        made = 0;
        n    = chan_limit();
        for (f = 0; f < frames; f++) begin
            start = (f % chunk_len) == 0;
            for (c = 0; c < n; c++) begin
                if ($urandom_range(0, 15) == 0) continue;
                if ($urandom_range(0, 11) == 0)
                    made += add_sample(pick_sample(), CHAN_W'($urandom_range(0, 15)),
                                       1'($urandom_range(0, 1)), made == drain_at);
                else
                    made += add_sample(pick_sample(), CHAN_W'(c), start, made == drain_at);
            end
        end
        return made;
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= 100) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_ORDER_MASK:    cfg_mask         = data[MASK_W-1:0];
            REG_HALF_STEP:     cfg_step         = data[STEP_W-1:0];
            REG_ALWAYS_RESET:  cfg_always_reset = data[0];
            REG_CHANNEL_COUNT: cfg_chans        = data[CCNT_W-1:0];
            default: ;
        endcase
    endtask

    // all words sent and received, then let any word without output finish
    task automatic wait_idle();
        do @(negedge i_clk);
        while (samples_todo.size() != 0 || in_if.valid || integrals_due.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            in_gap      <= 0;
        end else begin
            if (in_if.valid && in_if.ready)
                trapezoid_step(in_if.sample, in_if.channel, in_if.chunk_start);
            if (!in_if.valid || in_if.ready) begin
                if (in_gap != 0) begin
                    in_gap      <= in_gap - 1;
                    in_if.valid <= 1'b0;
                end else if (samples_todo.size() != 0 &&
                             !(samples_todo[0].drain_first && integrals_due.size() != 0)) begin
                    nxt               = samples_todo.pop_front();
                    in_if.sample      <= nxt.sample;
                    in_if.channel     <= nxt.channel;
                    in_if.chunk_start <= nxt.start;
                    in_if.valid       <= 1'b1;
                    in_gap            <= no_gaps_in ? 0 : pick_gap();
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // output monitor and back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            out_hold     <= 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (integrals_due.size() == 0) begin
                    report_mismatch($sformatf("word with nothing due: value %0d order %0d last %0b",
                                              out_if.value, out_if.order, out_if.last));
                end else begin
                    due = integrals_due.pop_front();
                    if (out_if.value !== due.value || out_if.order !== due.order ||
                        out_if.last !== due.last)
                        report_mismatch($sformatf("got value %0d order %0d last %0b, want %0d %0d %0b",
                                                  out_if.value, out_if.order, out_if.last,
                                                  due.value, due.order, due.last));
                end
            end
            if (out_hold != 0) begin
                out_if.ready <= 1'b0;
                out_hold     <= out_hold - 1;
            end else begin
                out_if.ready <= 1'b1;
                out_hold     <= no_stall_out ? 0 : pick_gap();
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus
    initial begin
        int                random_made;
        int                phase;
        int                c;
        int                f;
        int                n;
        logic [MASK_W-1:0] mask;
        logic [STEP_W-1:0] step;
        logic              ar;
        logic [CCNT_W-1:0] chans;

        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = REG_ORDER_MASK;
        i_cfg_data        = '0;
        in_if.valid       = 1'b0;
        in_if.sample      = '0;
        in_if.channel     = '0;
        in_if.chunk_start = 1'b0;
        out_if.ready      = 1'b0;
        no_gaps_in        = 1'b1;
        no_stall_out      = 1'b1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: all orders, half step one half, one channel
        void'(add_sample(32'h7FFF_FFFF, 4'd0, 1'b1, 1'b0));
        void'(add_sample(32'h8000_0000, 4'd0, 1'b0, 1'b0));
        void'(add_sample(32'h7FFF_FFFF, 4'd0, 1'b1, 1'b0));
        void'(add_sample('0, 4'd0, 1'b0, 1'b0));
        void'(add_sample(32'h0000_0001, 4'd0, 1'b0, 1'b1));
        void'(add_sample(32'hFFFF_FFFF, 4'd0, 1'b0, 1'b0));
        wait_idle();

        // empty mask: words accepted, nothing produced, no history touched
        write_reg(REG_ORDER_MASK, {27'($urandom), 5'd0});
        void'(add_sample($urandom, 4'd9, 1'b1, 1'b0));
        void'(add_sample($urandom, 4'd15, 1'b0, 1'b0));
        wait_idle();

        // orders 0, 2 and 4, largest half step, three channels, restart on chunk start
        write_reg(REG_ORDER_MASK, {27'($urandom), 5'b10101});
        write_reg(REG_HALF_STEP, 32'hFFFF_FFFF);
        write_reg(REG_ALWAYS_RESET, {31'($urandom), 1'b1});
        write_reg(REG_CHANNEL_COUNT, {27'($urandom), 5'd3});
        for (c = 0; c < 3; c++) void'(add_sample(pick_sample(), CHAN_W'(c), 1'b1, 1'b0));
        for (c = 0; c < 3; c++) void'(add_sample(pick_sample(), CHAN_W'(c), 1'b0, 1'b0));
        void'(add_sample(32'h8000_0000, 4'd2, 1'b1, 1'b0));
        void'(add_sample(32'h7FFF_FFFF, 4'd15, 1'b1, 1'b0));
        void'(add_sample(32'h8000_0000, 4'd15, 1'b0, 1'b0));
        wait_idle();

        // channel count zero acts as one; order 0 only; smallest half step
        write_reg(REG_ORDER_MASK, {27'($urandom), 5'd1});
        write_reg(REG_HALF_STEP, 32'd1);
        write_reg(REG_ALWAYS_RESET, {31'($urandom), 1'b0});
        write_reg(REG_CHANNEL_COUNT, {27'($urandom), 5'd0});
        void'(add_sample(pick_sample(), 4'd0, 1'b0, 1'b0));
        void'(add_sample(pick_sample(), 4'd1, 1'b1, 1'b0));
        void'(add_sample(pick_sample(), 4'd0, 1'b0, 1'b0));
        wait_idle();

        // random settings, frames with random content
        random_made = 0;
        for (phase = 0; random_made < 50; phase++) begin
            case ($urandom_range(0, 4))
                0:       mask = 5'd31;
                1:       mask = 5'd1;
                2:       mask = 5'd16;
                default: mask = 5'($urandom_range(1, 31));
            endcase
            case ($urandom_range(0, 3))
                0:       step = 32'd1;
                1:       step = 32'hFFFF_FFFF;
                default: step = $urandom;
            endcase
            ar = (phase == 0) ? 1'b1 : 1'($urandom_range(0, 1));
            if (phase == 0) begin
                chans = 5'd16;
            end else begin
                case ($urandom_range(0, 5))
                    0:       chans = 5'($urandom_range(17, 31));
                    1:       chans = 5'd16;
                    default: chans = 5'($urandom_range(1, 16));
                endcase
            end
            write_reg(REG_ORDER_MASK, {27'($urandom), mask});
            write_reg(REG_HALF_STEP, step);
            write_reg(REG_ALWAYS_RESET, {31'($urandom), ar});
            write_reg(REG_CHANNEL_COUNT, {27'($urandom), chans});
            no_gaps_in   = $urandom_range(0, 3) == 0;
            no_stall_out = $urandom_range(0, 3) == 0;
            n = chan_limit();
            random_made += queue_frames((20 / n < 2) ? 2 : 20 / n, $urandom_range(1, 4),
                                        $urandom_range(2, 8));
            wait_idle();
        end

        // two channels of opposite full-scale input drive the integrals into saturation
        write_reg(REG_ORDER_MASK, {27'($urandom), 5'd31});
        write_reg(REG_HALF_STEP, 32'hFFFF_FFFF);
        write_reg(REG_ALWAYS_RESET, {31'($urandom), 1'b1});
        write_reg(REG_CHANNEL_COUNT, {27'($urandom), 5'd2});
        no_gaps_in   = 1'b0;
        no_stall_out = 1'b0;
        for (f = 0; f < 25; f++) begin
            void'(add_sample(32'h7FFF_FFFF, 4'd0, f == 0, f == 12));
            void'(add_sample(32'h8000_0000, 4'd1, f == 0, 1'b0));
        end
        wait_idle();

        if (integrals_due.size() != 0)
            report_mismatch($sformatf("%0d words never arrived", integrals_due.size()));
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/cti_pkg.sv
hw/rtl/cti_in_if.sv
hw/rtl/cti_out_if.sv
hw/rtl/cti_hist_mem.sv
hw/rtl/cti_scale.sv
hw/rtl/cascaded_trapezoid_integrator.sv
dv/tb.sv
